### rtl/core/gyro_to_mouse_delta_core_defines.svh
// assertion macros for the gyro to mouse delta core checker
// expects signals clk and arst_n in the scope of use
`ifndef GYRO_TO_MOUSE_DELTA_CORE_DEFINES_SVH
`define GYRO_TO_MOUSE_DELTA_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GTMD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define GTMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/gtmd_pkg.sv
// shared types and constants for the gyro to mouse delta core
// no dependencies
package gtmd_pkg;

	// default fraction bits of smoothed rates and accumulators
	localparam int FRAC_BITS_DEF = 8;

	// stream and register port widths
	localparam int S_DATA_W   = 40;
	localparam int M_DATA_W   = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEAD_ZONE   = 3'd0,
		CFG_SPEED_GAIN  = 3'd1,
		CFG_MAX_DELTA   = 3'd2,
		CFG_SMOOTH_KEEP = 3'd3,
		CFG_IDLE_DECAY  = 3'd4
	} cfg_idx_t;

	// register reset values
	localparam logic [14:0] DEAD_ZONE_RST   = 15'd64;
	localparam logic [11:0] SPEED_GAIN_RST  = 12'd512;
	localparam logic [6:0]  MAX_DELTA_RST   = 7'd120;
	localparam logic [15:0] SMOOTH_KEEP_RST = 16'd47186;
	localparam logic [15:0] IDLE_DECAY_RST  = 16'd39322;

	// 24-bit saturation bounds
	localparam logic signed [23:0] ACC_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] ACC_MIN = 24'sh800000;

	// step strobes from the sequencer to the lanes and the merge stage
	typedef struct packed {
		logic load;
		logic mul_keep;
		logic mul_new;
		logic smooth;
		logic zone;
		logic mul_acc;
		logic add;
		logic whole;
		logic commit;
	} lane_ctl_t;

endpackage

### rtl/core/gtmd_lane.sv
// one axis lane: rate smoothing, dead zone, fraction accumulator, whole delta
// depends on gtmd_pkg
module gtmd_lane #(
	parameter int FRAC_BITS = gtmd_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gtmd_pkg::lane_ctl_t ctl,
	input  logic signed [15:0] rate,
	input  logic [14:0]        dead_zone,
	input  logic [11:0]        speed_gain,
	input  logic [6:0]         max_delta,
	input  logic [15:0]        smooth_keep,
	input  logic [15:0]        idle_decay,
	output logic signed [7:0]  move
);
	import gtmd_pkg::*;

	localparam int NEW_W = 34 + FRAC_BITS;
	localparam int SUM_W = ((NEW_W > 41) ? NEW_W : 41) + 1;
	localparam int SH_W  = SUM_W - 16;
	localparam int DZ_W  = 15 + FRAC_BITS;
	localparam int CMP_W = ((DZ_W > 24) ? DZ_W : 24) + 1;
	localparam logic signed [23:0]      FRAC_BIAS  = 24'((1 << FRAC_BITS) - 1);
	localparam logic signed [42:0]      DECAY_BIAS = 43'sd65535;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32'sd32768);

	logic signed [15:0] rate_q;
	logic signed [23:0] smooth_q;
	logic signed [23:0] acc_q;
	logic signed [40:0] keep_prod_q;
	logic signed [42:0] prod_q;
	logic [23:0]        diff_q;
	logic               in_zone_q;
	logic               neg_q;
	logic signed [7:0]  w_q;

	// shared multiplier operands
	logic [16:0]        new_weight;
	logic signed [24:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [42:0] mul_p;

	assign new_weight = 17'h10000 - {1'b0, smooth_keep};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		priority if (ctl.mul_keep) begin
			mul_a = {smooth_q[23], smooth_q};
			mul_b = {2'b00, smooth_keep};
		end else if (ctl.mul_new) begin
			mul_a = 25'(rate_q);
			mul_b = {1'b0, new_weight};
		end else if (in_zone_q) begin
			mul_a = {acc_q[23], acc_q};
			mul_b = {2'b00, idle_decay};
		end else begin
			mul_a = {1'b0, diff_q};
			mul_b = {6'd0, speed_gain};
		end
	end

	assign mul_p = mul_a * mul_b;

	// exponential average with round half up and saturation
	logic signed [SUM_W-1:0] keep_ext;
	logic signed [SUM_W-1:0] new_ext;
	logic signed [SUM_W-1:0] smooth_sum;
	logic signed [SH_W-1:0]  smooth_sh;
	logic signed [23:0]      smooth_sat;

	assign keep_ext   = SUM_W'(keep_prod_q);
	assign new_ext    = SUM_W'($signed(prod_q[33:0])) <<< FRAC_BITS;
	assign smooth_sum = keep_ext + new_ext + ROUND_HALF;
	assign smooth_sh  = smooth_sum[SUM_W-1:16];

	always_comb begin
		priority if (smooth_sh > ACC_MAX) begin
			smooth_sat = ACC_MAX;
		end else if (smooth_sh < ACC_MIN) begin
			smooth_sat = ACC_MIN;
		end else begin
			smooth_sat = smooth_sh[23:0];
		end
	end

	// magnitude against dead zone; drive is the negated smoothed rate
	logic signed [24:0] s_ext;
	logic signed [24:0] s_abs;
	logic [DZ_W-1:0]    dz;
	logic [CMP_W-1:0]   mag_ext;
	logic [CMP_W-1:0]   dz_ext;
	logic [CMP_W-1:0]   diff_full;

	assign s_ext     = {smooth_q[23], smooth_q};
	assign s_abs     = smooth_q[23] ? -s_ext : s_ext;
	assign dz        = {dead_zone, {FRAC_BITS{1'b0}}};
	assign mag_ext   = CMP_W'(s_abs[23:0]);
	assign dz_ext    = CMP_W'(dz);
	assign diff_full = mag_ext - dz_ext;

	// decay toward zero or add the gained step
	logic signed [42:0] decay_b;
	logic signed [23:0] gain_d;
	logic signed [23:0] step_d;
	logic signed [24:0] acc_sum;
	logic signed [23:0] acc_next;

	assign decay_b = prod_q + (prod_q[42] ? DECAY_BIAS : 43'sd0);
	assign gain_d  = prod_q[35:12];
	assign step_d  = neg_q ? -gain_d : gain_d;
	assign acc_sum = {acc_q[23], acc_q} + {step_d[23], step_d};

	always_comb begin
		priority if (in_zone_q) begin
			acc_next = decay_b[39:16];
		end else if (acc_sum > 25'(ACC_MAX)) begin
			acc_next = ACC_MAX;
		end else if (acc_sum < 25'(ACC_MIN)) begin
			acc_next = ACC_MIN;
		end else begin
			acc_next = acc_sum[23:0];
		end
	end

	// whole part toward zero, clamped
	logic signed [23:0] acc_b;
	logic signed [23:0] whole;
	logic signed [7:0]  lim;
	logic signed [23:0] lim_ext;
	logic signed [7:0]  w_next;

	assign acc_b   = acc_q + (acc_q[23] ? FRAC_BIAS : 24'sd0);
	assign whole   = acc_b >>> FRAC_BITS;
	assign lim     = {1'b0, max_delta};
	assign lim_ext = 24'(lim);

	always_comb begin
		priority if (in_zone_q) begin
			w_next = '0;
		end else if (whole > lim_ext) begin
			w_next = lim;
		end else if (whole < -lim_ext) begin
			w_next = -lim;
		end else begin
			w_next = whole[7:0];
		end
	end

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			acc_q    <= '0;
		end else begin
			if (ctl.smooth) begin
				smooth_q <= smooth_sat;
			end
			if (ctl.add) begin
				acc_q <= acc_next;
			end else if (ctl.commit) begin
				acc_q <= acc_q - (24'(w_q) <<< FRAC_BITS);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rate_q <= rate;
		end
		if (ctl.mul_keep) begin
			keep_prod_q <= mul_p[40:0];
		end
		if (ctl.mul_new || ctl.mul_acc) begin
			prod_q <= mul_p;
		end
		if (ctl.zone) begin
			in_zone_q <= mag_ext < dz_ext;
			neg_q     <= !smooth_q[23] && (smooth_q != 24'sd0);
			diff_q    <= diff_full[23:0];
		end
		if (ctl.whole) begin
			w_q <= w_next;
		end
	end

	assign move = w_q;

endmodule

### rtl/core/gtmd_merge.sv
// merge stage: report decision, button history and output register
// depends on gtmd_pkg
module gtmd_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  gtmd_pkg::lane_ctl_t ctl,
	input  logic                left_down,
	input  logic                right_down,
	input  logic                host_ready,
	input  logic signed [7:0]   dx,
	input  logic signed [7:0]   dy,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                send_report,
	output logic [1:0]          button_bits,
	output logic signed [7:0]   move_x,
	output logic signed [7:0]   move_y
);
	import gtmd_pkg::*;

	logic [1:0] btn_q;
	logic       ready_q;
	logic [1:0] sent_q;
	logic       never_q;
	logic       valid_q;
	logic       send_q;
	logic [1:0] bits_q;
	logic signed [7:0] mx_q;
	logic signed [7:0] my_q;
	logic       send;

	// report when ready and something moved, changed or nothing went out yet
	assign send = ready_q && ((dx != 8'sd0) || (dy != 8'sd0) || (btn_q != sent_q) || never_q);

	// control and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_q  <= '0;
			never_q <= 1'b1;
		end else begin
			if (ctl.commit) begin
				valid_q <= 1'b1;
				if (send) begin
					sent_q  <= btn_q;
					never_q <= 1'b0;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// item inputs and result payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			btn_q   <= {right_down, left_down};
			ready_q <= host_ready;
		end
		if (ctl.commit) begin
			send_q <= send;
			bits_q <= send ? btn_q : 2'b00;
			mx_q   <= send ? dx : 8'sd0;
			my_q   <= send ? dy : 8'sd0;
		end
	end

	assign out_valid   = valid_q;
	assign send_report = send_q;
	assign button_bits = bits_q;
	assign move_x      = mx_q;
	assign move_y      = my_q;

endmodule

### rtl/core/gyro_to_mouse_delta_core.sv
// top level of the gyro to mouse delta core: registers, sequencer, two lanes, merge
// depends on gtmd_pkg, gtmd_lane, gtmd_merge
//
// channel   dir  fields (lsb first)
// s_        in   rate_x[15:0] rate_z[31:16] left_down[32] right_down[33] host_ready[34]
// m_        out  send_report[0] button_bits[2:1] move_x[10:3] move_y[18:11]
// wr_       in   register index, data; written whenever wr_en is high
//
// one item passes through the accept and eight sequencer steps, a sequence set by the
// single multiplier each lane shares between smoothing, decay and gain
// both lanes run the same steps at once; the merge stage forms the report
// the last step waits while the output register holds an untaken result
// s_tready is high only while the sequencer is idle; working and payload regs lack reset
module gyro_to_mouse_delta_core #(
	parameter int FRAC_BITS = gtmd_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [gtmd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [gtmd_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// rate_x, rate_z, left_down, right_down, host_ready, zero pad
	input  logic [gtmd_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// send_report, button_bits, move_x, move_y, zero pad
	output logic [gtmd_pkg::M_DATA_W-1:0]   m_tdata
);
	import gtmd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_KEEP,
		ST_MUL_NEW,
		ST_SMOOTH,
		ST_ZONE,
		ST_MUL_ACC,
		ST_ADD,
		ST_WHOLE,
		ST_COMMIT
	} state_t;

	state_t state_q;

	logic [14:0] dead_zone_q;
	logic [11:0] speed_gain_q;
	logic [6:0]  max_delta_q;
	logic [15:0] smooth_keep_q;
	logic [15:0] idle_decay_q;

	lane_ctl_t ctl;
	logic signed [7:0] dx;
	logic signed [7:0] dy;
	logic              send_report;
	logic [1:0]        button_bits;
	logic signed [7:0] move_x;
	logic signed [7:0] move_y;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q   <= DEAD_ZONE_RST;
			speed_gain_q  <= SPEED_GAIN_RST;
			max_delta_q   <= MAX_DELTA_RST;
			smooth_keep_q <= SMOOTH_KEEP_RST;
			idle_decay_q  <= IDLE_DECAY_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_DEAD_ZONE:   dead_zone_q   <= wr_data[14:0];
				CFG_SPEED_GAIN:  speed_gain_q  <= wr_data[11:0];
				CFG_MAX_DELTA:   max_delta_q   <= wr_data[6:0];
				CFG_SMOOTH_KEEP: smooth_keep_q <= wr_data;
				CFG_IDLE_DECAY:  idle_decay_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// step strobes
	always_comb begin
		ctl          = '0;
		ctl.load     = (state_q == ST_IDLE) && s_tvalid;
		ctl.mul_keep = (state_q == ST_MUL_KEEP);
		ctl.mul_new  = (state_q == ST_MUL_NEW);
		ctl.smooth   = (state_q == ST_SMOOTH);
		ctl.zone     = (state_q == ST_ZONE);
		ctl.mul_acc  = (state_q == ST_MUL_ACC);
		ctl.add      = (state_q == ST_ADD);
		ctl.whole    = (state_q == ST_WHOLE);
		ctl.commit   = (state_q == ST_COMMIT) && (!m_tvalid || m_tready);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:     if (s_tvalid) state_q <= ST_MUL_KEEP;
				ST_MUL_KEEP: state_q <= ST_MUL_NEW;
				ST_MUL_NEW:  state_q <= ST_SMOOTH;
				ST_SMOOTH:   state_q <= ST_ZONE;
				ST_ZONE:     state_q <= ST_MUL_ACC;
				ST_MUL_ACC:  state_q <= ST_ADD;
				ST_ADD:      state_q <= ST_WHOLE;
				ST_WHOLE:    state_q <= ST_COMMIT;
				ST_COMMIT:   if (ctl.commit) state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// horizontal lane driven by z rate
	gtmd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.rate        ($signed(s_tdata[31:16])),
		.dead_zone   (dead_zone_q),
		.speed_gain  (speed_gain_q),
		.max_delta   (max_delta_q),
		.smooth_keep (smooth_keep_q),
		.idle_decay  (idle_decay_q),
		.move        (dx)
	);

	// vertical lane driven by x rate
	gtmd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.rate        ($signed(s_tdata[15:0])),
		.dead_zone   (dead_zone_q),
		.speed_gain  (speed_gain_q),
		.max_delta   (max_delta_q),
		.smooth_keep (smooth_keep_q),
		.idle_decay  (idle_decay_q),
		.move        (dy)
	);

	gtmd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.left_down   (s_tdata[32]),
		.right_down  (s_tdata[33]),
		.host_ready  (s_tdata[34]),
		.dx          (dx),
		.dy          (dy),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.send_report (send_report),
		.button_bits (button_bits),
		.move_x      (move_x),
		.move_y      (move_y)
	);

	assign m_tdata = {5'd0, move_y, move_x, button_bits, send_report};

endmodule

### rtl/core/gtmd_checker.sv
// port-level checker for the gyro to mouse delta core, bound to the top level
// depends on gtmd_pkg and gyro_to_mouse_delta_core_defines.svh
`include "gyro_to_mouse_delta_core_defines.svh"

module gtmd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [gtmd_pkg::S_DATA_W-1:0] s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [gtmd_pkg::M_DATA_W-1:0] m_tdata
);
	import gtmd_pkg::*;

	logic in_take;
	logic pad_zero;

	assign in_take  = s_tvalid && s_tready && (s_tdata[S_DATA_W-1] || !s_tdata[S_DATA_W-1]);
	assign pad_zero = (m_tdata[M_DATA_W-1:19] == '0);

	// one item in flight: no accept right after an accept
	`GTMD_ASSERT_NEXT(a_one_in_flight, in_take, !s_tready, "item accepted while busy")

	// a held result stays put
	`GTMD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// no report means empty fields
	`GTMD_ASSERT_NOW(a_quiet_empty, m_tvalid && !m_tdata[0], m_tdata[18:1] == 18'd0 && pad_zero, "fields set without a report")

	// deltas stay within the clamp range
	`GTMD_ASSERT_NOW(a_delta_range, m_tvalid, m_tdata[10:3] != 8'h80 && m_tdata[18:11] != 8'h80, "delta out of range")

endmodule

bind gyro_to_mouse_delta_core gtmd_checker u_gtmd_checker (.*);

### dv/testbench.sv
// self-checking testbench for gyro_to_mouse_delta_core: report ticks in, mouse reports out
// predicts every report with its own model of smoothing, dead zone and accumulators
// depends on gtmd_pkg and the core rtl
module testbench;
	import gtmd_pkg::*;

	// one report tick as offered on the input stream
	typedef struct {
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_z;
		logic               left;
		logic               right;
		logic               ready;
	} tick_t;

	// one mouse report as seen on the output stream
	typedef struct packed {
		logic              send;
		logic [1:0]        buttons;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
	} report_t;

	// predicted reports and their comparison against the core
	class report_board;
		longint dead_zone, speed_gain, max_delta, smooth_keep, idle_decay;
		longint sm_x, sm_z, acc_x, acc_y;
		logic [1:0] sent_btn;
		logic never_sent;
		report_t pending[$];
		int mismatches, ticks, reports_sent;

		function new();
			dead_zone   = DEAD_ZONE_RST;
			speed_gain  = SPEED_GAIN_RST;
			max_delta   = MAX_DELTA_RST;
			smooth_keep = SMOOTH_KEEP_RST;
			idle_decay  = IDLE_DECAY_RST;
			sm_x = 0;
			sm_z = 0;
			acc_x = 0;
			acc_y = 0;
			sent_btn = 2'b00;
			never_sent = 1'b1;
			mismatches = 0;
			ticks = 0;
			reports_sent = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] v);
			case (idx)
				CFG_DEAD_ZONE:   dead_zone   = v[14:0];
				CFG_SPEED_GAIN:  speed_gain  = v[11:0];
				CFG_MAX_DELTA:   max_delta   = v[6:0];
				CFG_SMOOTH_KEEP: smooth_keep = v;
				CFG_IDLE_DECAY:  idle_decay  = v;
				default: ;
			endcase
		endfunction

		function longint sat24(longint v);
			if (v > longint'(ACC_MAX)) return longint'(ACC_MAX);
			if (v < longint'(ACC_MIN)) return longint'(ACC_MIN);
			return v;
		endfunction

		// shift right rounding toward zero
		function longint trunc_shr(longint v, int n);
			if (v >= 0) return v >>> n;
			return -((-v) >>> n);
		endfunction

		// q16 exponential average, round half up, saturated
		function longint smooth(longint s, logic signed [15:0] rate);
			longint sum;
			sum = s * smooth_keep
				+ longint'(rate) * (longint'(1) << FRAC_BITS_DEF) * (65536 - smooth_keep);
			return sat24((sum + 32768) >>> 16);
		endfunction

		// dead zone, decay or gain, whole-part extraction for one axis
		function void axis_step(input longint v, inout longint acc, output longint w);
			longint a, dz, d;
			a = (v < 0) ? -v : v;
			dz = dead_zone * (longint'(1) << FRAC_BITS_DEF);
			if (a < dz) begin
				acc = trunc_shr(acc * idle_decay, 16);
				w = 0;
			end else begin
				d = ((a - dz) * speed_gain) >>> 12;
				if (v < 0) d = -d;
				acc = sat24(acc + d);
				w = trunc_shr(acc, FRAC_BITS_DEF);
				if (w > max_delta) w = max_delta;
				if (w < -max_delta) w = -max_delta;
				acc = acc - w * (longint'(1) << FRAC_BITS_DEF);
			end
		endfunction

		function void note_tick(tick_t t);
			report_t r;
			longint dx, dy;
			logic [1:0] btn;
			btn = {t.right, t.left};
			sm_x = smooth(sm_x, t.rate_x);
			sm_z = smooth(sm_z, t.rate_z);
			axis_step(-sm_z, acc_x, dx);
			axis_step(-sm_x, acc_y, dy);
			r = '0;
			if (t.ready && (dx != 0 || dy != 0 || btn != sent_btn || never_sent)) begin
				sent_btn = btn;
				never_sent = 1'b0;
				r.send = 1'b1;
				r.buttons = btn;
				r.move_x = dx[7:0];
				r.move_y = dy[7:0];
			end
			pending.push_back(r);
			ticks++;
		endfunction

		function void flag(string what, int want, int got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %0s: expected %0d, got %0d (tick %0d)",
					what, want, got, ticks - pending.size());
		endfunction

		function void check_report(logic [M_DATA_W-1:0] data);
			report_t want, got;
			got.send = data[0];
			got.buttons = data[2:1];
			got.move_x = data[10:3];
			got.move_y = data[18:11];
			if (pending.size() == 0) begin
				flag("unexpected report, send_report", -1, got.send);
				return;
			end
			want = pending.pop_front();
			if (got.send !== want.send) flag("send_report", want.send, got.send);
			if (got.buttons !== want.buttons) flag("button_bits", want.buttons, got.buttons);
			if (got.move_x !== want.move_x) flag("move_x", want.move_x, got.move_x);
			if (got.move_y !== want.move_y) flag("move_y", want.move_y, got.move_y);
			if (want.send) reports_sent++;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = CFG_DEAD_ZONE;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// rate_x, rate_z, left_down, right_down, host_ready, zero pad
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// send_report, button_bits, move_x, move_y, zero pad
	logic [M_DATA_W-1:0]   m_tdata;

	logic no_idle = 1'b0;
	logic want_hold = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   phases = 0;

	report_board board = new();

	gyro_to_mouse_delta_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock, period 20
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (want_hold && !hold_done) begin
			hold_left <= 80;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= 7);
		end
	end

	// report check on every accepted item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_report(m_tdata);
	end

	function automatic tick_t mk(int rx, int rz, bit l, bit r, bit rdy);
		tick_t t;
		t.rate_x = rx[15:0];
		t.rate_z = rz[15:0];
		t.left = l;
		t.right = r;
		t.ready = rdy;
		return t;
	endfunction

	// rate with a spread from near the dead zone up to full scale
	function automatic int pick_rate();
		case ($urandom_range(3))
			0: return int'($urandom_range(2047)) - 1024;
			1: return int'($urandom_range(16383)) - 8192;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	// offer one item and hold it until taken, then maybe leave a gap
	task automatic send_tick(tick_t t);
		s_tdata <= {5'b0, t.ready, t.right, t.left, t.rate_z, t.rate_x};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_tick(t);
		if (!no_idle && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// stop offering until every report is back, then let the core drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		board.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic load_regs(int dz, int gain, int maxd, int keep, int decay);
		write_reg(CFG_DEAD_ZONE, dz[15:0]);
		write_reg(CFG_SPEED_GAIN, gain[15:0]);
		write_reg(CFG_MAX_DELTA, maxd[15:0]);
		write_reg(CFG_SMOOTH_KEEP, keep[15:0]);
		write_reg(CFG_IDLE_DECAY, decay[15:0]);
		wr_en <= 1'b0;
		phases++;
	endtask

	// gesture-shaped random ticks: held rates with jitter, some pure noise
	task automatic random_ticks(int count);
		int rx, rz, hold;
		bit l, r;
		rx = 0;
		rz = 0;
		hold = 0;
		l = 0;
		r = 0;
		repeat (count) begin
			if (hold == 0) begin
				rx = pick_rate();
				rz = pick_rate();
				hold = $urandom_range(1, 12);
			end
			hold--;
			if ($urandom_range(99) < 15) l = $urandom_range(1);
			if ($urandom_range(99) < 15) r = $urandom_range(1);
			if ($urandom_range(9) == 0)
				send_tick(mk($urandom_range(65535), $urandom_range(65535), l, r,
					$urandom_range(1)));
			else
				send_tick(mk(rx + int'($urandom_range(63)) - 32,
					rz + int'($urandom_range(63)) - 32, l, r, $urandom_range(9) != 0));
		end
	endtask

	// main sequence
	initial begin
		int dz, keep;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first report, buttons, full-scale rates, lost deltas, decay
		send_tick(mk(0, 0, 0, 0, 0));
		send_tick(mk(0, 0, 0, 0, 1));
		send_tick(mk(0, 0, 0, 0, 1));
		send_tick(mk(0, 0, 1, 0, 1));
		send_tick(mk(0, 0, 1, 1, 0));
		send_tick(mk(0, 0, 0, 1, 1));
		repeat (3) send_tick(mk(32767, -32768, 0, 1, 1));
		repeat (2) send_tick(mk(-32768, 32767, 0, 1, 0));
		send_tick(mk(-32768, 32767, 0, 1, 1));
		repeat (3) send_tick(mk(0, 0, 0, 1, 1));
		settle();

		// no smoothing: rate exactly at the dead zone, just inside, zero max delta
		load_regs(100, 4095, 0, 0, 0);
		send_tick(mk(-100, 100, 0, 1, 1));
		send_tick(mk(99, -99, 0, 1, 1));
		send_tick(mk(20000, -20000, 0, 1, 1));
		settle();

		// saturation of smoothed values and accumulators
		load_regs(0, 4095, 127, 0, 65535);
		repeat (3) send_tick(mk(-32768, -32768, 0, 1, 1));
		repeat (2) send_tick(mk(32767, 32767, 0, 1, 1));
		repeat (2) send_tick(mk(0, 0, 0, 1, 1));
		settle();

		// reset settings again, with a long receiver hold-off to back up the input
		load_regs(DEAD_ZONE_RST, SPEED_GAIN_RST, MAX_DELTA_RST, SMOOTH_KEEP_RST,
			IDLE_DECAY_RST);
		want_hold <= 1'b1;
		random_ticks(120);
		settle();

		// high extremes with no idling on either side
		load_regs(0, 4095, 127, 0, 65535);
		no_idle <= 1'b1;
		random_ticks(60);
		settle();
		no_idle <= 1'b0;

		// low extremes
		load_regs(32767, 0, 1, 65535, 0);
		random_ticks(30);
		settle();

		// random settings, dead zone and smoothing mostly in useful ranges
		repeat (5) begin
			dz = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(511);
			keep = ($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(32767, 65535);
			load_regs(dz, $urandom_range(4095), $urandom_range(1, 127), keep,
				$urandom_range(65535));
			random_ticks(80);
			settle();
		end

		$display("covered %0d ticks over %0d register settings, %0d reports sent",
			board.ticks, phases, board.reports_sent);
		$display("mismatches: %0d, reports still owed: %0d",
			board.mismatches, board.pending.size());
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("timeout with %0d reports owed", board.pending.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
